[hdl/nsps_pkg.sv]
// Shared types and constants of the nearest successor/predecessor search block.
`default_nettype none
package nsps_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_W       = 2;

  // Configuration port.
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_COUNT = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_ABOVE = 2'd1,
    CMD_BELOW = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    logic                  below;
    logic [CNT_W-1:0]      limit;
    logic [IDX_W-1:0]      idx;
    logic [VALUE_BITS-1:0] ref_val;
    logic                  have;
    logic [VALUE_BITS-1:0] best;
    logic [IDX_W-1:0]      best_pos;
  } tok_t;

endpackage
`default_nettype wire

[hdl/nsps_in_if.sv]
// Input channel: one command transaction per handshake.
`default_nettype none
interface nsps_in_if;
  import nsps_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic [IDX_W-1:0]             slot;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output command, output slot, output value, input ready);
  modport sink   (input valid, input command, input slot, input value, output ready);
endinterface
`default_nettype wire

[hdl/nsps_out_if.sv]
// Output channel: one search result transaction per handshake.
`default_nettype none
interface nsps_out_if;
  import nsps_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface
`default_nettype wire

[hdl/nearest_successor_predecessor_search.sv]
// Top level: cell chain, command control, result register and APB register.
//
// Usage: commands arrive on in_i. A write command stores value into entry slot
// and gives no result; command code 3 is dropped. A query (above
// or below) searches the first active_count entries and returns one result on
// out_o: found and the position of the nearest entry strictly above or below
// the query value, lowest slot on ties, position 0 when nothing qualifies.
// A query token enters the first cell when accepted and moves one cell per
// cycle along the 64-cell chain; its result then passes the result register
// into the output register on out_o; the input is closed until then. Writes
// keep it open. The result sits in an output register, so a new command
// is taken while it waits; if a second query finishes before the first result
// is taken, its result is held and the input stays closed until out_o drains.
// active_count is written through the APB port at address 0; the user must
// do so only while idle, which the block does not enforce. Larger values than
// 64 search the whole table. Reset clears the control state, the output valid
// flag and active_count; the table contents are undefined until written.
`default_nettype none
module nearest_successor_predecessor_search (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  nsps_in_if.sink                                  in_i,
  nsps_out_if.source                               out_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [nsps_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [nsps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [nsps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);
  import nsps_pkg::*;

  state_e                state_q;
  state_e                state_d;
  logic [CNT_W-1:0]      active_count_q;
  logic                  in_acc;
  logic                  wr_acc;
  logic                  qry_acc;
  logic                  qry_below;
  logic                  load_out;
  logic                  res_found_q;
  logic [IDX_W-1:0]      res_pos_q;
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic                  out_found_q;
  logic [IDX_W-1:0]      out_pos_q;
  logic [TABLE_DEPTH-1:0] wr_en;
  tok_t                  tok [TABLE_DEPTH+1];

  // Command decode.
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    wr_acc    = 1'b0;
    qry_acc   = 1'b0;
    qry_below = 1'b0;
    case (cmd_e'(in_i.command))
      CMD_WRITE: wr_acc = in_acc;
      CMD_ABOVE: qry_acc = in_acc;
      CMD_BELOW: begin
        qry_acc   = in_acc;
        qry_below = 1'b1;
      end
      default: begin
        wr_acc  = 1'b0;
        qry_acc = 1'b0;
      end
    endcase
  end

  always_comb begin
    tok[0].valid    = qry_acc;
    tok[0].below    = qry_below;
    tok[0].limit    = active_count_q;
    tok[0].idx      = '0;
    tok[0].ref_val  = in_i.value;
    tok[0].have     = 1'b0;
    tok[0].best     = '0;
    tok[0].best_pos = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign wr_en[i] = wr_acc && (in_i.slot == IDX_W'(i));

    nsps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[i]),
      .wr_value_i (in_i.value),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  // Control state machine.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (qry_acc) state_d = ST_SCAN;
      ST_SCAN: if (tok[TABLE_DEPTH].valid) state_d = ST_HOLD;
      ST_HOLD: if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_SCAN: in_i.ready = 1'b0;
      ST_HOLD: load_out = !out_valid_q || out_o.ready;
      default: in_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result capture as the token leaves the last cell.
  always_ff @(posedge clk_i) begin
    if (tok[TABLE_DEPTH].valid) begin
      res_found_q <= tok[TABLE_DEPTH].have;
      res_pos_q   <= tok[TABLE_DEPTH].have ? tok[TABLE_DEPTH].best_pos : '0;
    end
  end

  // Output register.
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_pos_q;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_ACTIVE_COUNT)) begin
      active_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr == ADDR_ACTIVE_COUNT) begin
      prdata = APB_DATA_W'(active_count_q);
    end else begin
      prdata = '0;
    end
  end

endmodule
`default_nettype wire

[hdl/nsps_cell.sv]
// One table cell: holds one entry and updates the passing search token.
`default_nettype none
module nsps_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [nsps_pkg::VALUE_BITS-1:0] wr_value_i,
  input  wire nsps_pkg::tok_t                 tok_i,
  output nsps_pkg::tok_t                      tok_o
);
  import nsps_pkg::*;

  logic [VALUE_BITS-1:0] entry_q;
  tok_t                  tok_d;
  tok_t                  tok_q;
  logic                  active;
  logic                  gt_ref;
  logic                  lt_ref;
  logic                  gt_best;
  logic                  lt_best;
  logic                  hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_value_i;
    end
  end

  always_comb begin
    active  = {1'b0, tok_i.idx} < tok_i.limit;
    gt_ref  = $signed(entry_q) > $signed(tok_i.ref_val);
    lt_ref  = $signed(entry_q) < $signed(tok_i.ref_val);
    gt_best = $signed(entry_q) > $signed(tok_i.best);
    lt_best = $signed(entry_q) < $signed(tok_i.best);
    // Strict improvement only, so the lowest slot keeps a tie.
    if (tok_i.below) begin
      hit = lt_ref && (!tok_i.have || gt_best);
    end else begin
      hit = gt_ref && (!tok_i.have || lt_best);
    end

    tok_d     = tok_i;
    tok_d.idx = tok_i.idx + IDX_W'(1);
    if (tok_i.valid && active && hit) begin
      tok_d.have     = 1'b1;
      tok_d.best     = entry_q;
      tok_d.best_pos = tok_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

[tb/nsps_checker.sv]
// Checker for the search block: watches both channels and the APB port, predicts and compares.
module nsps_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  nsps_in_if                                   in_mon,
  nsps_out_if                                  out_mon,
  input  wire logic                            psel_i,
  input  wire logic                            penable_i,
  input  wire logic                            pwrite_i,
  input  wire logic                            pready_i,
  input  wire logic [nsps_pkg::APB_ADDR_W-1:0] paddr_i,
  input  wire logic [nsps_pkg::APB_DATA_W-1:0] pwdata_i,
  output int unsigned                          mismatch_count_o,
  output int unsigned                          pending_o
);
  import nsps_pkg::*;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } search_answer_t;

  logic signed [VALUE_BITS-1:0] entry_mem [TABLE_DEPTH];
  logic [CNT_W-1:0]             search_len = '0;
  search_answer_t               search_answers [$];
  search_answer_t               oldest;
  int unsigned                  mismatches = 0;

  // Nearest entry strictly above or below the probe among the searched slots;
  // the lowest slot wins among equal candidates.
  function automatic search_answer_t nearest_entry(input cmd_e                         cmd,
                                                   input logic signed [VALUE_BITS-1:0] probe);
    search_answer_t               ans;
    logic signed [VALUE_BITS-1:0] best;
    int                           span;
    int                           i;
    ans  = '0;
    best = '0;
    span = (search_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_len);
    for (i = 0; i < span; i++) begin
      if (cmd == CMD_ABOVE) begin
        if (entry_mem[i] > probe && (!ans.found || entry_mem[i] < best)) begin
          best         = entry_mem[i];
          ans.found    = 1'b1;
          ans.position = IDX_W'(i);
        end
      end else begin
        if (entry_mem[i] < probe && (!ans.found || entry_mem[i] > best)) begin
          best         = entry_mem[i];
          ans.found    = 1'b1;
          ans.position = IDX_W'(i);
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_len = '0;
      search_answers.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_ACTIVE_COUNT) begin
        search_len = pwdata_i[CNT_W-1:0];
      end

      if (out_mon.valid && out_mon.ready) begin
        if (search_answers.size() == 0) begin
          $error("search result with no query outstanding: found %0d position %0d",
                 out_mon.found, out_mon.position);
          mismatches++;
        end else begin
          oldest = search_answers.pop_front();
          if (out_mon.found !== oldest.found) begin
            $error("found: expected %0d, actual %0d", oldest.found, out_mon.found);
            mismatches++;
          end
          if (out_mon.position !== oldest.position) begin
            $error("position: expected %0d, actual %0d", oldest.position, out_mon.position);
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.command)
          CMD_WRITE: entry_mem[in_mon.slot] = in_mon.value;
          CMD_ABOVE, CMD_BELOW:
            search_answers.push_back(nearest_entry(cmd_e'(in_mon.command), in_mon.value));
          default: ;  // the unused command code is dropped without a result
        endcase
      end

      pending_o <= search_answers.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

[tb/nearest_successor_predecessor_search_test.sv]
// Testbench top: clock, reset, stimulus, result sink, watchdog and verdict.
module nearest_successor_predecessor_search_test;
  import nsps_pkg::*;

  localparam logic [CMD_W-1:0]             CMD_UNUSED       = 2'd3;
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN          = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX          = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam int unsigned                  WATCHDOG_LIMIT   = 3000;
  localparam int unsigned                  SINK_HOLD_CYCLES = 400;
  localparam int unsigned                  WRITE_SETTLE     = 4;
  localparam int unsigned                  TAIL_CYCLES      = 80;
  localparam int unsigned                  PHASE_ITEMS      = 143;
  localparam int                           NUM_PHASES       = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned quiet_cycles = 0;
  int unsigned active_count = 0;
  bit          calm = 1'b0;
  bit          sink_hold_req = 1'b0;
  bit          written [TABLE_DEPTH];

  nsps_in_if  in_bus ();
  nsps_out_if out_bus ();

  nearest_successor_predecessor_search u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nsps_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Values lean toward a narrow band so that ties and near misses are common.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int narrow;
    narrow = int'($urandom_range(12)) - 6;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0:       pick_value = VAL_MIN;
          1:       pick_value = VAL_MIN + 1;
          2:       pick_value = VAL_MAX - 1;
          3:       pick_value = VAL_MAX;
          4:       pick_value = '0;
          default: pick_value = '1;
        endcase
      end
      1, 2, 3: pick_value = narrow;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic offer_command(input logic [CMD_W-1:0]             cmd,
                               input logic [IDX_W-1:0]             slot,
                               input logic signed [VALUE_BITS-1:0] val);
    if (!calm && $urandom_range(99) < 11) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(4) == 0) ? 70 : 3)) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.slot    <= slot;
    in_bus.value   <= val;
    do @(posedge clk_i); while (!in_bus.ready);
    if (cmd == CMD_WRITE) written[slot] = 1'b1;
  endtask

  // The pending count is registered, so it lags the acceptance edge; hence the first edge.
  task automatic wait_idle(input int unsigned settle);
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_active_count(input int unsigned count);
    wait_idle(WRITE_SETTLE);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_COUNT;
    pwdata  <= count;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    active_count = count;
  endtask

  task automatic offer_random_item(output bit counted);
    int unsigned      pick;
    int unsigned      span;
    int unsigned      gap;
    int unsigned      i;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] slot;
    pick = $urandom_range(99);
    slot = IDX_W'($urandom_range(TABLE_DEPTH - 1));
    span = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
    gap  = TABLE_DEPTH;
    for (i = 0; i < span; i++) begin
      if (!written[i] && gap == TABLE_DEPTH) gap = i;
    end
    if (pick < 4)       cmd = CMD_UNUSED;
    else if (pick < 40) cmd = CMD_WRITE;
    else if (pick < 70) cmd = CMD_ABOVE;
    else                cmd = CMD_BELOW;
    // A query must never search a slot that has not been written yet.
    if ((cmd == CMD_ABOVE || cmd == CMD_BELOW) && gap < span) begin
      cmd  = CMD_WRITE;
      slot = IDX_W'(gap);
    end
    offer_command(cmd, slot, pick_value());
    counted = (cmd != CMD_UNUSED);
  endtask

  initial begin : result_sink
    bit hold_done;
    hold_done     = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req && !hold_done) begin
        // Hold results back long enough for the block to fill and close its input.
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_counts [NUM_PHASES] = '{1, 64, 127, 0, 65, 5, 33, 100, 8, 64};
    int unsigned done;
    int          p;
    bit          counted;

    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.command = CMD_WRITE;
    in_bus.slot    = '0;
    in_bus.value   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing is searched after reset, so queries find nothing.
    offer_command(CMD_ABOVE, '0, '0);
    offer_command(CMD_BELOW, '1, VAL_MAX);
    offer_command(CMD_UNUSED, 6'd21, 7);

    offer_command(CMD_WRITE, 6'd0, VAL_MIN);
    offer_command(CMD_WRITE, 6'd1, VAL_MAX);
    offer_command(CMD_WRITE, 6'd2, 0);
    offer_command(CMD_WRITE, 6'd3, -1);
    offer_command(CMD_WRITE, 6'd4, 5);
    offer_command(CMD_WRITE, 6'd5, 5);
    offer_command(CMD_WRITE, 6'd6, 1);
    offer_command(CMD_WRITE, 6'd7, VAL_MIN);
    set_active_count(8);

    offer_command(CMD_ABOVE, IDX_W'($urandom), VAL_MIN);
    offer_command(CMD_BELOW, IDX_W'($urandom), VAL_MAX);
    offer_command(CMD_ABOVE, IDX_W'($urandom), VAL_MAX);
    offer_command(CMD_BELOW, IDX_W'($urandom), VAL_MIN);
    offer_command(CMD_ABOVE, IDX_W'($urandom), -1);
    offer_command(CMD_BELOW, IDX_W'($urandom), 0);
    offer_command(CMD_ABOVE, IDX_W'($urandom), 4);
    offer_command(CMD_BELOW, IDX_W'($urandom), 6);
    offer_command(CMD_ABOVE, IDX_W'($urandom), 5);
    offer_command(CMD_BELOW, IDX_W'($urandom), VAL_MIN + 1);
    offer_command(CMD_UNUSED, IDX_W'($urandom), pick_value());

    for (p = 0; p < NUM_PHASES; p++) begin
      set_active_count(phase_counts[p]);
      calm <= (p == 5);
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (p == 1 && done == 60) sink_hold_req <= 1'b1;
        offer_random_item(counted);
        if (counted) done++;
      end
    end

    wait_idle(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/nsps_pkg.sv
hdl/nsps_in_if.sv
hdl/nsps_out_if.sv
hdl/nsps_cell.sv
hdl/nearest_successor_predecessor_search.sv
tb/nsps_checker.sv
tb/nearest_successor_predecessor_search_test.sv
